@@ rtl/recorded_track_follow_blender_unit_defines.svh @@
// ----------------------------------------------------------------------------
// recorded track follow blender defines
// assertion macros for the files that check the block's own logic
// ----------------------------------------------------------------------------
`ifndef RECORDED_TRACK_FOLLOW_BLENDER_UNIT_DEFINES_SVH
`define RECORDED_TRACK_FOLLOW_BLENDER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RTFB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define RTFB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RTFB_ASSERT_IMPL(lbl, ante, cons, msg)
`define RTFB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/rtfb_pkg.sv @@
// ----------------------------------------------------------------------------
// rtfb_pkg
// types, widths, micro-op codes and the control program of the blender
// ----------------------------------------------------------------------------
package rtfb_pkg;

  // track storage bound and step index width
  localparam int unsigned MAX_STEPS = 1024;
  localparam int unsigned STEP_W    = $clog2(MAX_STEPS);

  // field widths
  localparam int unsigned TICK_W     = 32;
  localparam int unsigned SONIC_W    = 10;
  localparam int unsigned FLAG_W     = 2;
  localparam int unsigned DUTY_W     = 16;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned WEIGHT_W   = 8;
  localparam int unsigned NEXT_W     = 10;

  // configuration port
  localparam int unsigned GAIN_W    = 4;
  localparam int unsigned THRESH_W  = 8;
  localparam int unsigned TLEN_W    = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LANE_THRESHOLD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_LENGTH     = 2'd2;

  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 4'd2;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd5;
  localparam logic [TLEN_W-1:0]   TLEN_RESET   = 11'd1024;

  // direction codes
  localparam logic [FLAG_W-1:0] DIR_STRAIGHT  = 2'd0;
  localparam logic [FLAG_W-1:0] DIR_RIGHT_ERR = 2'd2;
  localparam logic [FLAG_W-1:0] DIR_LEFT_ERR  = 2'd3;

  typedef struct packed {
    logic                  running;
    logic [TICK_W-1:0]     now_ms;
    logic [SONIC_W-1:0]    dist_left;
    logic [SONIC_W-1:0]    dist_mid;
    logic [SONIC_W-1:0]    dist_right;
    logic [FLAG_W-1:0]     rec_flag;
    logic [DUTY_W-1:0]     rec_speed_left;
    logic [DUTY_W-1:0]     rec_speed_right;
    logic [SONIC_W-1:0]    rec_sonic_left;
    logic [SONIC_W-1:0]    rec_sonic_mid;
    logic [SONIC_W-1:0]    rec_sonic_right;
    logic [INTERVAL_W-1:0] rec_interval;
  } item_t;

  typedef struct packed {
    logic [FLAG_W-1:0]   drive_direction;
    logic [DUTY_W-1:0]   drive_left;
    logic [DUTY_W-1:0]   drive_right;
    logic [WEIGHT_W-1:0] blend_weight;
    logic [NEXT_W-1:0]   next_step;
  } result_t;

  // micro-ops
  localparam int unsigned OP_W = 4;
  localparam logic [OP_W-1:0] OP_FETCH  = 4'd0;
  localparam logic [OP_W-1:0] OP_SMOOTH = 4'd1;
  localparam logic [OP_W-1:0] OP_ERR    = 4'd2;
  localparam logic [OP_W-1:0] OP_DIV3   = 4'd3;
  localparam logic [OP_W-1:0] OP_GAIN   = 4'd4;
  localparam logic [OP_W-1:0] OP_MULA   = 4'd5;
  localparam logic [OP_W-1:0] OP_MACB   = 4'd6;
  localparam logic [OP_W-1:0] OP_DIVE   = 4'd7;
  localparam logic [OP_W-1:0] OP_FIX    = 4'd8;
  localparam logic [OP_W-1:0] OP_IDLE   = 4'd9;
  localparam logic [OP_W-1:0] OP_EMIT   = 4'd10;

  // sequencing conditions
  localparam int unsigned COND_W = 3;
  localparam logic [COND_W-1:0] C_SEQ      = 3'd0;
  localparam logic [COND_W-1:0] C_JUMP     = 3'd1;
  localparam logic [COND_W-1:0] C_WAIT_IN  = 3'd2;
  localparam logic [COND_W-1:0] C_IF_IDLE  = 3'd3;
  localparam logic [COND_W-1:0] C_WAIT_OUT = 3'd4;

  // program addresses
  localparam int unsigned PC_W = 4;
  localparam logic [PC_W-1:0] PC_FETCH  = 4'd0;
  localparam logic [PC_W-1:0] PC_SMOOTH = 4'd1;
  localparam logic [PC_W-1:0] PC_ERR    = 4'd2;
  localparam logic [PC_W-1:0] PC_DIV3   = 4'd3;
  localparam logic [PC_W-1:0] PC_GAIN   = 4'd4;
  localparam logic [PC_W-1:0] PC_MULA   = 4'd5;
  localparam logic [PC_W-1:0] PC_MACB   = 4'd6;
  localparam logic [PC_W-1:0] PC_DIVE   = 4'd7;
  localparam logic [PC_W-1:0] PC_FIX    = 4'd8;
  localparam logic [PC_W-1:0] PC_IDLE   = 4'd9;
  localparam logic [PC_W-1:0] PC_EMIT   = 4'd10;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic running;
    logic out_busy;
  } status_t;

  // control store
  function automatic ctrl_t rom_word(input logic [PC_W-1:0] pc);
    ctrl_t w;
    unique case (pc)
      PC_FETCH:  w = '{op: OP_FETCH,  cond: C_WAIT_IN,  target: PC_FETCH};
      PC_SMOOTH: w = '{op: OP_SMOOTH, cond: C_IF_IDLE,  target: PC_IDLE};
      PC_ERR:    w = '{op: OP_ERR,    cond: C_SEQ,      target: PC_FETCH};
      PC_DIV3:   w = '{op: OP_DIV3,   cond: C_SEQ,      target: PC_FETCH};
      PC_GAIN:   w = '{op: OP_GAIN,   cond: C_SEQ,      target: PC_FETCH};
      PC_MULA:   w = '{op: OP_MULA,   cond: C_SEQ,      target: PC_FETCH};
      PC_MACB:   w = '{op: OP_MACB,   cond: C_SEQ,      target: PC_FETCH};
      PC_DIVE:   w = '{op: OP_DIVE,   cond: C_SEQ,      target: PC_FETCH};
      PC_FIX:    w = '{op: OP_FIX,    cond: C_JUMP,     target: PC_EMIT};
      PC_IDLE:   w = '{op: OP_IDLE,   cond: C_SEQ,      target: PC_FETCH};
      PC_EMIT:   w = '{op: OP_EMIT,   cond: C_WAIT_OUT, target: PC_FETCH};
      default:   w = '{op: OP_FETCH,  cond: C_JUMP,     target: PC_FETCH};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/rtfb_stream_if.sv @@
// ----------------------------------------------------------------------------
// rtfb stream interfaces
// valid/ready channels carrying input words and result words
// ----------------------------------------------------------------------------
interface rtfb_item_if;
  rtfb_pkg::item_t data;
  logic            valid;
  logic            ready;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rtfb_result_if;
  rtfb_pkg::result_t data;
  logic              valid;
  logic              ready;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/rtfb_seq.sv @@
// ----------------------------------------------------------------------------
// rtfb_seq
// step counter and control store, emits one control word per cycle
// ----------------------------------------------------------------------------
module rtfb_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rtfb_pkg::status_t status_i,
  output rtfb_pkg::ctrl_t   ctrl_o
);
  import rtfb_pkg::*;

  logic [PC_W-1:0] step_q, step_d, pc_inc;
  ctrl_t           ctrl;

  always_comb begin
    ctrl   = rom_word(step_q);
    pc_inc = step_q + PC_W'(1);
    unique case (ctrl.cond)
      C_SEQ:      step_d = pc_inc;
      C_JUMP:     step_d = ctrl.target;
      C_WAIT_IN:  step_d = status_i.in_valid ? pc_inc : step_q;
      C_IF_IDLE:  step_d = status_i.running ? pc_inc : ctrl.target;
      C_WAIT_OUT: step_d = status_i.out_busy ? step_q : ctrl.target;
      default:    step_d = PC_FETCH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= PC_FETCH;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = ctrl;

endmodule

@@ rtl/rtfb_dp.sv @@
// ----------------------------------------------------------------------------
// rtfb_dp
// datapath: filters, error and weight unit, two duty lanes, step timer
// ----------------------------------------------------------------------------
module rtfb_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rtfb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rtfb_pkg::CFG_DAT_W-1:0] cfg_wdata_i,
  input  rtfb_pkg::ctrl_t                ctrl_i,
  input  logic                           item_valid_i,
  input  rtfb_pkg::item_t                item_i,
  output logic                           running_o,
  output rtfb_pkg::result_t              result_o
);
  import rtfb_pkg::*;

  localparam int unsigned LANES  = 2;
  localparam int unsigned ACC_W  = 24;
  localparam int unsigned SUM_W  = SONIC_W + 2;
  localparam int unsigned QUOT_W = SONIC_W;
  localparam int unsigned GP_W   = QUOT_W + GAIN_W;
  localparam logic [SUM_W-1:0]    DIV3_MUL   = 12'd2731;
  localparam int unsigned         DIV3_SHIFT = 13;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 8'd255;

  function automatic logic [SONIC_W-1:0] smooth8(input logic [SONIC_W-1:0] y,
                                                 input logic [SONIC_W-1:0] x);
    logic [SONIC_W:0] diff;
    if (x >= y) begin
      diff = {1'b0, x} - {1'b0, y};
      return y + SONIC_W'(diff >> 3);
    end
    diff = {1'b0, y} - {1'b0, x} + (SONIC_W + 1)'(7);
    return y - SONIC_W'(diff >> 3);
  endfunction

  function automatic logic [SONIC_W-1:0] absdiff(input logic [SONIC_W-1:0] a,
                                                 input logic [SONIC_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // configuration
  logic [GAIN_W-1:0]   gain_q;
  logic [THRESH_W-1:0] thresh_q;
  logic [TLEN_W-1:0]   tlen_q;

  // architectural state
  logic [SONIC_W-1:0] smooth_l_q, smooth_m_q, smooth_r_q;
  logic [STEP_W-1:0]  idx_q;
  logic [TICK_W-1:0]  start_q;
  logic [DUTY_W-1:0]  last_q [LANES];

  // working registers
  item_t               item_q;
  logic [SUM_W-1:0]    sum_q;
  logic [FLAG_W-1:0]   dir_q;
  logic [QUOT_W-1:0]   quot3_q;
  logic [WEIGHT_W-1:0] weight_q;
  logic [ACC_W-1:0]    acc_q [LANES];
  logic [DUTY_W-1:0]   qe_q  [LANES];
  logic [DUTY_W-1:0]   res_q [LANES];

  // combinational
  logic [SONIC_W-1:0]  el_c, em_c, er_c;
  logic [SUM_W-1:0]    sum_c;
  logic [FLAG_W-1:0]   dir_c;
  logic [2*SUM_W-1:0]  div3_prod;
  logic [GP_W-1:0]     gain_prod;
  logic [WEIGHT_W-1:0] weight_c;
  logic [DUTY_W-1:0]   speed_c  [LANES];
  logic [ACC_W-1:0]    mul_a_c  [LANES];
  logic [ACC_W-1:0]    mul_b_c  [LANES];
  logic [ACC_W:0]      dsum_c   [LANES];
  logic [ACC_W-1:0]    rem_c    [LANES];
  logic [DUTY_W-1:0]   fix_c    [LANES];
  logic [TICK_W-1:0]   elapsed_c;
  logic                advance_c;
  logic [TLEN_W-1:0]   bound_c;
  logic [STEP_W:0]     idx_inc_c;
  logic [STEP_W-1:0]   idx_next_c;

  always_comb begin
    el_c  = absdiff(smooth_l_q, item_q.rec_sonic_left);
    em_c  = absdiff(smooth_m_q, item_q.rec_sonic_mid);
    er_c  = absdiff(smooth_r_q, item_q.rec_sonic_right);
    sum_c = SUM_W'(el_c) + SUM_W'(em_c) + SUM_W'(er_c);

    dir_c = item_q.rec_flag;
    if (item_q.rec_flag == DIR_STRAIGHT) begin
      if (el_c > SONIC_W'(thresh_q))      dir_c = DIR_LEFT_ERR;
      else if (er_c > SONIC_W'(thresh_q)) dir_c = DIR_RIGHT_ERR;
      else                                dir_c = DIR_STRAIGHT;
    end

    // divide by three through a reciprocal, exact for the sum's range
    div3_prod = (2*SUM_W)'(sum_q) * (2*SUM_W)'(DIV3_MUL);
    gain_prod = GP_W'(quot3_q) * GP_W'(gain_q);
    weight_c  = (gain_prod > GP_W'(WEIGHT_MAX)) ? WEIGHT_MAX : WEIGHT_W'(gain_prod);

    speed_c[0] = item_q.rec_speed_left;
    speed_c[1] = item_q.rec_speed_right;
    for (int k = 0; k < LANES; k++) begin
      mul_a_c[k] = ACC_W'(weight_q) * ACC_W'(last_q[k]);
      mul_b_c[k] = ACC_W'(WEIGHT_MAX - weight_q) * ACC_W'(speed_c[k]);
      // x/255 estimate, low by at most one
      dsum_c[k]  = (ACC_W + 1)'(acc_q[k]) + (ACC_W + 1)'(acc_q[k] >> 8)
                 + (ACC_W + 1)'(acc_q[k] >> 16);
      rem_c[k]   = acc_q[k] - ((ACC_W'(qe_q[k]) << 8) - ACC_W'(qe_q[k]));
      fix_c[k]   = qe_q[k] + DUTY_W'(rem_c[k] >= ACC_W'(WEIGHT_MAX));
    end

    elapsed_c  = item_q.now_ms - start_q;
    advance_c  = elapsed_c > TICK_W'(item_q.rec_interval);
    bound_c    = (tlen_q > TLEN_W'(MAX_STEPS)) ? TLEN_W'(MAX_STEPS) : tlen_q;
    idx_inc_c  = {1'b0, idx_q} + (STEP_W + 1)'(1);
    idx_next_c = (TLEN_W'(idx_inc_c) >= bound_c) ? '0 : idx_inc_c[STEP_W-1:0];
  end

  // configuration and block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q     <= GAIN_RESET;
      thresh_q   <= THRESH_RESET;
      tlen_q     <= TLEN_RESET;
      smooth_l_q <= '0;
      smooth_m_q <= '0;
      smooth_r_q <= '0;
      idx_q      <= '0;
      start_q    <= '0;
      for (int k = 0; k < LANES; k++) last_q[k] <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SENSITIVITY_GAIN: gain_q   <= cfg_wdata_i[GAIN_W-1:0];
          CFG_LANE_THRESHOLD:   thresh_q <= cfg_wdata_i[THRESH_W-1:0];
          CFG_TRACK_LENGTH:     tlen_q   <= cfg_wdata_i[TLEN_W-1:0];
          default: ;
        endcase
      end
      unique case (ctrl_i.op)
        OP_SMOOTH: begin
          // a zero start tick counts as unset
          if (start_q == '0) start_q <= item_q.now_ms;
          if (item_q.running) begin
            smooth_l_q <= smooth8(smooth_l_q, item_q.dist_left);
            smooth_m_q <= smooth8(smooth_m_q, item_q.dist_mid);
            smooth_r_q <= smooth8(smooth_r_q, item_q.dist_right);
          end
        end
        OP_FIX: begin
          for (int k = 0; k < LANES; k++) last_q[k] <= fix_c[k];
          if (advance_c) begin
            idx_q   <= idx_next_c;
            start_q <= item_q.now_ms;
          end
        end
        OP_IDLE: begin
          for (int k = 0; k < LANES; k++) last_q[k] <= '0;
          start_q <= item_q.now_ms;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      OP_FETCH: if (item_valid_i) item_q <= item_i;
      OP_ERR: begin
        sum_q <= sum_c;
        dir_q <= dir_c;
      end
      OP_DIV3: quot3_q  <= QUOT_W'(div3_prod >> DIV3_SHIFT);
      OP_GAIN: weight_q <= weight_c;
      OP_MULA: for (int k = 0; k < LANES; k++) acc_q[k] <= mul_a_c[k];
      OP_MACB: for (int k = 0; k < LANES; k++) acc_q[k] <= acc_q[k] + mul_b_c[k];
      OP_DIVE: for (int k = 0; k < LANES; k++) qe_q[k] <= dsum_c[k][DUTY_W+7:8];
      OP_FIX:  for (int k = 0; k < LANES; k++) res_q[k] <= fix_c[k];
      OP_IDLE: begin
        for (int k = 0; k < LANES; k++) res_q[k] <= '0;
        weight_q <= '0;
        dir_q    <= DIR_STRAIGHT;
      end
      default: ;
    endcase
  end

  assign running_o = item_q.running;

  always_comb begin
    result_o.drive_direction = dir_q;
    result_o.drive_left      = res_q[0];
    result_o.drive_right     = res_q[1];
    result_o.blend_weight    = weight_q;
    result_o.next_step       = NEXT_W'(idx_q);
  end

endmodule

@@ rtl/recorded_track_follow_blender_unit.sv @@
// ----------------------------------------------------------------------------
// recorded_track_follow_blender_unit
// follows a recorded track, blending recorded duties with the last duties
//
// item_i carries one input word per control tick: running flag, tick time,
// three raw distances and the record of the current step. result_o returns
// one result word per input word, in order. cfg_we_i writes a register at
// cfg_idx_i with no wait: 0 sensitivity gain, 1 lane threshold, 2 track
// length; write only while the block is idle.
// a microcoded sequencer walks an eleven-step program over a shared
// datapath. a running word goes through fetch, smooth, error, divide,
// gain, multiply, accumulate, estimate, fix and emit into the result
// register; a stopped word goes through fetch, smooth, zero and emit,
// as the program jumps straight to the zeroing step; one word at a time.
// after reset the filters, duties, step index and start tick are zero and
// the registers hold their reset values. a stalled receiver holds the
// result register; the next word is still taken and worked on, and waits
// at the emit step until the register frees.
// ----------------------------------------------------------------------------
`include "recorded_track_follow_blender_unit_defines.svh"

module recorded_track_follow_blender_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rtfb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rtfb_pkg::CFG_DAT_W-1:0] cfg_wdata_i,
  rtfb_item_if.sink                      item_i,
  rtfb_result_if.source                  result_o
);
  import rtfb_pkg::*;

  ctrl_t   ctrl;
  status_t status;
  result_t dp_result;
  logic    dp_running;

  // output register parts the sequencer from the receiver
  result_t out_data_q;
  logic    out_valid_q;
  logic    out_load;

  // input word is taken only at the fetch step
  assign item_i.ready = (ctrl.op == OP_FETCH);

  assign out_load = (ctrl.op == OP_EMIT) && (!out_valid_q || result_o.ready);

  always_comb begin
    status.in_valid = item_i.valid;
    status.running  = dp_running;
    status.out_busy = out_valid_q && !result_o.ready;
  end

  rtfb_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  rtfb_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .ctrl_i       (ctrl),
    .item_valid_i (item_i.valid),
    .item_i       (item_i.data),
    .running_o    (dp_running),
    .result_o     (dp_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_data_q <= dp_result;
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_data_q;

  // an accepted word always starts the filter step next
  `RTFB_ASSERT_NEXT(a_fetch_then_smooth, item_i.valid && item_i.ready, ctrl.op == OP_SMOOTH, "fetch not followed by smooth step")
  // no second word is taken right behind the first
  `RTFB_ASSERT_NEXT(a_single_fetch, item_i.valid && item_i.ready, !item_i.ready, "back-to-back fetch")
  // a new result only appears out of the emit step
  `RTFB_ASSERT_IMPL(a_valid_from_emit, $rose(out_valid_q), $past(ctrl.op == OP_EMIT), "result valid without emit")
  // a stopped word yields zero weight and zero duties
  `RTFB_ASSERT_NEXT(a_idle_zero, out_load && !dp_running, out_data_q.blend_weight == '0 && out_data_q.drive_left == '0 && out_data_q.drive_right == '0, "stopped word gave nonzero result")

endmodule

@@ tb/recorded_track_follow_blender_unit_tb.sv @@
// ----------------------------------------------------------------------------
// recorded_track_follow_blender_unit_tb
// self-checking bench for the track follow blender: a directed opening
// (start tick handling, step timing edges, tick wrap, steering thresholds,
// weight clamp, stopped words) then random phases under several register
// settings, each word predicted on acceptance and its result checked in order
// ----------------------------------------------------------------------------
module recorded_track_follow_blender_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rtfb_pkg::*;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES   = 6;
  localparam int unsigned PHASE_WORDS    = 195;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned DRAIN_CYCLES   = 30;
  // longest legal quiet stretch is the receiver hold-off, so allow ten times that
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DIST_TOP       = (1 << SONIC_W) - 1;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DAT_W-1:0] cfg_wdata_i;

  rtfb_item_if   item_bus ();
  rtfb_result_if res_bus ();

  recorded_track_follow_blender_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_bus),
    .result_o    (res_bus)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // words waiting for the driver, and results the block still owes us
  item_t   pending_words[$];
  result_t expected_drives[$];

  // predictor copy of the registers
  logic [GAIN_W-1:0]   cfg_gain   = GAIN_RESET;
  logic [THRESH_W-1:0] cfg_thresh = THRESH_RESET;
  logic [TLEN_W-1:0]   cfg_tlen   = TLEN_RESET;

  // predictor copy of the block state
  logic [SONIC_W-1:0] flt_left  = '0;
  logic [SONIC_W-1:0] flt_mid   = '0;
  logic [SONIC_W-1:0] flt_right = '0;
  int unsigned        track_pos = 0;
  logic [TICK_W-1:0]  step_start = '0;
  logic [DUTY_W-1:0]  duty_left  = '0;
  logic [DUTY_W-1:0]  duty_right = '0;

  // handshake bookkeeping shared by driver, receiver and monitor
  bit          item_taken     = 1'b0;
  bit          result_taken   = 1'b0;
  bit          sender_burst   = 1'b0;
  bit          receiver_burst = 1'b0;
  bit          hold_req       = 1'b0;
  int unsigned send_gap       = 0;
  int unsigned recv_gap       = 0;
  int unsigned hold_left      = 0;
  int unsigned quiet_cycles   = 0;

  // run statistics
  int unsigned words_queued    = 0;
  int unsigned words_taken     = 0;
  int unsigned stopped_words   = 0;
  int unsigned step_advances   = 0;
  int unsigned step_wraps      = 0;
  int unsigned results_checked = 0;
  int unsigned settings_used   = 1;
  int unsigned errors          = 0;

  // random stimulus context: a running tick and a slowly changing scene
  logic [TICK_W-1:0] tick = '0;
  int                scene_left;
  int                scene_mid;
  int                scene_right;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // one-eighth exponential filter, floor of the signed step
  function automatic logic [SONIC_W-1:0] smooth_eighth(logic [SONIC_W-1:0] y,
                                                       logic [SONIC_W-1:0] x);
    int unsigned yy;
    int unsigned xx;
    yy = y;
    xx = x;
    if (xx >= yy) return SONIC_W'(yy + ((xx - yy) >> 3));
    return SONIC_W'(yy - ((yy - xx + 7) >> 3));
  endfunction

  function automatic int unsigned sonic_gap(logic [SONIC_W-1:0] a, logic [SONIC_W-1:0] b);
    return (a >= b) ? int'(a - b) : int'(b - a);
  endfunction

  // advances the predicted state by one word and returns the result it owes
  function automatic result_t follow_step(item_t w);
    result_t     r;
    int unsigned el;
    int unsigned em;
    int unsigned er;
    int unsigned wt;
    int unsigned bound;
    logic [TICK_W-1:0] elapsed;
    r = '0;
    // a start tick of zero means not yet set
    if (step_start == '0) step_start = w.now_ms;
    if (w.running) begin
      flt_left  = smooth_eighth(flt_left, w.dist_left);
      flt_mid   = smooth_eighth(flt_mid, w.dist_mid);
      flt_right = smooth_eighth(flt_right, w.dist_right);
      el = sonic_gap(flt_left, w.rec_sonic_left);
      em = sonic_gap(flt_mid, w.rec_sonic_mid);
      er = sonic_gap(flt_right, w.rec_sonic_right);
      wt = (el + em + er) / 3 * cfg_gain;
      if (wt > 255) wt = 255;
      // steering only overrides straight steps
      r.drive_direction = w.rec_flag;
      if (w.rec_flag == DIR_STRAIGHT) begin
        if (el > cfg_thresh) r.drive_direction = DIR_LEFT_ERR;
        else if (er > cfg_thresh) r.drive_direction = DIR_RIGHT_ERR;
      end
      r.drive_left  = DUTY_W'((wt * duty_left + (255 - wt) * w.rec_speed_left) / 255);
      r.drive_right = DUTY_W'((wt * duty_right + (255 - wt) * w.rec_speed_right) / 255);
      r.blend_weight = WEIGHT_W'(wt);
      duty_left  = r.drive_left;
      duty_right = r.drive_right;
      elapsed = w.now_ms - step_start;
      if (elapsed > w.rec_interval) begin
        bound = (cfg_tlen > MAX_STEPS) ? MAX_STEPS : cfg_tlen;
        track_pos++;
        step_advances++;
        if (track_pos >= bound) begin
          track_pos = 0;
          step_wraps++;
        end
        step_start = w.now_ms;
      end
    end else begin
      duty_left  = '0;
      duty_right = '0;
      step_start = w.now_ms;
      stopped_words++;
    end
    r.next_step = NEXT_W'(track_pos);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int unsigned draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic logic [SONIC_W-1:0] clip_sonic(int v);
    if (v < 0) return '0;
    if (v > int'(DIST_TOP)) return SONIC_W'(DIST_TOP);
    return SONIC_W'(v);
  endfunction

  function automatic item_t make_word(bit run, logic [TICK_W-1:0] now,
                                      int unsigned dl, int unsigned dm, int unsigned dr,
                                      int unsigned flag, int unsigned vl, int unsigned vr,
                                      int unsigned sl, int unsigned sm, int unsigned sr,
                                      int unsigned iv);
    item_t w;
    w.running         = run;
    w.now_ms          = now;
    w.dist_left       = SONIC_W'(dl);
    w.dist_mid        = SONIC_W'(dm);
    w.dist_right      = SONIC_W'(dr);
    w.rec_flag        = FLAG_W'(flag);
    w.rec_speed_left  = DUTY_W'(vl);
    w.rec_speed_right = DUTY_W'(vr);
    w.rec_sonic_left  = SONIC_W'(sl);
    w.rec_sonic_mid   = SONIC_W'(sm);
    w.rec_sonic_right = SONIC_W'(sr);
    w.rec_interval    = INTERVAL_W'(iv);
    return w;
  endfunction

  // mostly a plausible drive: rising tick, distances near a scene, recorded
  // distances near the same scene at a random spread; the rest is pure noise
  function automatic item_t random_word();
    item_t       w;
    int unsigned pick;
    int          spread;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      return make_word($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom);
    end
    if ($urandom_range(0, 24) == 0) begin
      scene_left  = $urandom_range(0, DIST_TOP);
      scene_mid   = $urandom_range(0, DIST_TOP);
      scene_right = $urandom_range(0, DIST_TOP);
    end
    // tick: mostly steady, sometimes a jump or a run up to the wrap
    pick = $urandom_range(0, 99);
    if (pick < 3) tick = $urandom;
    else if (pick < 5) tick = 32'hFFFF_FFFF - $urandom_range(0, 300);
    else tick = tick + $urandom_range(1, 60);
    case ($urandom_range(0, 2))
      0:       spread = 3;
      1:       spread = 20;
      default: spread = 300;
    endcase
    w.running         = ($urandom_range(0, 15) != 0);
    w.now_ms          = tick;
    w.dist_left       = clip_sonic(scene_left + int'($urandom_range(0, 30)) - 15);
    w.dist_mid        = clip_sonic(scene_mid + int'($urandom_range(0, 30)) - 15);
    w.dist_right      = clip_sonic(scene_right + int'($urandom_range(0, 30)) - 15);
    w.rec_sonic_left  = clip_sonic(scene_left + int'($urandom_range(0, 2 * spread)) - spread);
    w.rec_sonic_mid   = clip_sonic(scene_mid + int'($urandom_range(0, 2 * spread)) - spread);
    w.rec_sonic_right = clip_sonic(scene_right + int'($urandom_range(0, 2 * spread)) - spread);
    w.rec_flag        = ($urandom_range(0, 9) < 7) ? DIR_STRAIGHT : FLAG_W'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      w.rec_speed_left  = $urandom_range(0, 1) ? '1 : '0;
      w.rec_speed_right = $urandom_range(0, 1) ? '1 : '0;
    end else begin
      w.rec_speed_left  = DUTY_W'($urandom);
      w.rec_speed_right = DUTY_W'($urandom);
    end
    pick = $urandom_range(0, 99);
    if (pick < 55) w.rec_interval = INTERVAL_W'($urandom_range(0, 120));
    else if (pick < 90) w.rec_interval = INTERVAL_W'($urandom_range(0, 2000));
    else w.rec_interval = INTERVAL_W'($urandom);
    return w;
  endfunction

  task automatic queue_word(item_t w);
    pending_words.push_back(w);
    words_queued++;
  endtask

  // sender holds back until every word is taken and every result is back
  task automatic wait_drained();
    while (words_taken != words_queued || expected_drives.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // one write per cycle, enable held high across the three writes
  task automatic write_regs(logic [CFG_DAT_W-1:0] gain, logic [CFG_DAT_W-1:0] thresh,
                            logic [CFG_DAT_W-1:0] tlen);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SENSITIVITY_GAIN;
    cfg_wdata_i <= gain;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_LANE_THRESHOLD;
    cfg_wdata_i <= thresh;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_TRACK_LENGTH;
    cfg_wdata_i <= tlen;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_gain   = GAIN_W'(gain);
    cfg_thresh = THRESH_W'(thresh);
    cfg_tlen   = TLEN_W'(tlen);
    settings_used++;
  endtask

  task automatic run_phase(logic [CFG_DAT_W-1:0] gain, logic [CFG_DAT_W-1:0] thresh,
                           logic [CFG_DAT_W-1:0] tlen, bit hold);
    write_regs(gain, thresh, tlen);
    // some phases run back to back on one side or both
    sender_burst   = hold || ($urandom_range(0, 3) == 0);
    receiver_burst = !hold && ($urandom_range(0, 3) == 0);
    if (hold) hold_req = 1'b1;
    repeat (PHASE_WORDS) queue_word(random_word());
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents the next pending word once the previous one is taken
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!item_bus.valid || item_taken) begin
        if (send_gap != 0) begin
          send_gap--;
          item_bus.valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          item_bus.data  <= pending_words.pop_front();
          item_bus.valid <= 1'b1;
          send_gap = draw_gap(sender_burst);
        end else begin
          item_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: stall after each result, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (result_taken) recv_gap = draw_gap(receiver_burst);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on every accepted word, check every accepted result
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    if (rst_ni) begin
      item_taken   <= item_bus.valid && item_bus.ready;
      result_taken <= res_bus.valid && res_bus.ready;
      if (item_bus.valid && item_bus.ready) begin
        expected_drives.push_back(follow_step(item_bus.data));
        words_taken++;
      end
      if (res_bus.valid && res_bus.ready) begin
        got = res_bus.data;
        if (expected_drives.size() == 0) begin
          $error("result word with no word outstanding: %h", got);
          errors++;
        end else begin
          want = expected_drives.pop_front();
          check_field("drive_direction", want.drive_direction, got.drive_direction);
          check_field("drive_left", want.drive_left, got.drive_left);
          check_field("drive_right", want.drive_right, got.drive_right);
          check_field("blend_weight", want.blend_weight, got.blend_weight);
          check_field("next_step", want.next_step, got.next_step);
          results_checked++;
        end
      end
      // watchdog on cycles with no handshake on either side
      if ((item_bus.valid && item_bus.ready) || (res_bus.valid && res_bus.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    item_bus.valid = 1'b0;
    item_bus.data  = '0;
    res_bus.ready  = 1'b0;
    scene_left     = $urandom_range(0, DIST_TOP);
    scene_mid      = $urandom_range(0, DIST_TOP);
    scene_right    = $urandom_range(0, DIST_TOP);
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed opening under reset register values; filters stay at zero
    // until the stopped word so the steering edges are exact
    // tick zero leaves the start unset, then the first nonzero tick sets it
    queue_word(make_word(1, 0, 0, 0, 0, DIR_STRAIGHT, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0));
    queue_word(make_word(1, 100, 0, 0, 0, DIR_STRAIGHT, 1234, 4321, 0, 0, 0, 50));
    // elapsed equal to the interval holds, one more advances
    queue_word(make_word(1, 150, 0, 0, 0, DIR_STRAIGHT, 7, 9, 0, 0, 0, 50));
    queue_word(make_word(1, 151, 0, 0, 0, DIR_STRAIGHT, 11, 13, 0, 0, 0, 50));
    // large side errors steer and clamp the weight
    queue_word(make_word(1, 160, 0, 0, 0, DIR_STRAIGHT, 0, 16'hFFFF, 1023, 0, 0, 16'hFFFF));
    queue_word(make_word(1, 170, 0, 0, 0, DIR_STRAIGHT, 16'hFFFF, 0, 0, 0, 1023, 16'hFFFF));
    // just over, just at the lane threshold
    queue_word(make_word(1, 180, 0, 0, 0, DIR_STRAIGHT, 100, 200, 6, 0, 0, 16'hFFFF));
    queue_word(make_word(1, 190, 0, 0, 0, DIR_STRAIGHT, 300, 400, 5, 0, 6, 16'hFFFF));
    queue_word(make_word(1, 200, 0, 0, 0, DIR_STRAIGHT, 500, 600, 5, 0, 5, 16'hFFFF));
    // non-straight codes pass through despite the error
    queue_word(make_word(1, 210, 0, 0, 0, 1, 1000, 2000, 1023, 0, 0, 16'hFFFF));
    queue_word(make_word(1, 220, 0, 0, 0, DIR_RIGHT_ERR, 3000, 4000, 1023, 0, 0, 16'hFFFF));
    queue_word(make_word(1, 230, 0, 0, 0, DIR_LEFT_ERR, 5000, 6000, 0, 0, 1023, 16'hFFFF));
    // stopped word with every distance and recorded field at its top
    queue_word(make_word(0, 300, 1023, 1023, 1023, DIR_LEFT_ERR, 16'hFFFF, 16'hFFFF,
                         1023, 1023, 1023, 16'hFFFF));
    // tick near the top, then across the wrap
    queue_word(make_word(1, 32'hFFFF_FFF0, 1023, 1023, 1023, DIR_LEFT_ERR, 16'hFFFF,
                         16'hFFFF, 0, 0, 0, 16'hFFFF));
    queue_word(make_word(1, 32'h10, 1023, 1023, 1023, DIR_STRAIGHT, 16'hFFFF, 0, 0, 0, 0, 40));
    queue_word(make_word(1, 32'h30, 1023, 1023, 1023, DIR_STRAIGHT, 0, 16'hFFFF, 0, 0, 0, 40));
    // zero interval advances on any elapsed tick
    queue_word(make_word(1, 32'h31, 0, 0, 0, DIR_STRAIGHT, 0, 0, 1023, 1023, 1023, 0));
    // stop at tick zero leaves the start unset again; tiny distances next
    queue_word(make_word(0, 0, 0, 0, 0, DIR_STRAIGHT, 0, 0, 0, 0, 0, 0));
    queue_word(make_word(1, 500, 1, 2, 1, DIR_STRAIGHT, 40, 50, 0, 1, 2, 0));
    queue_word(make_word(1, 501, 2, 0, 1, DIR_STRAIGHT, 60, 70, 3, 0, 0, 0));
    wait_drained();

    // random phases, each from an idle block; extremes and out-of-range lengths
    run_phase(0, 0, 1, 1'b0);
    run_phase(15, 255, 1024, 1'b1);
    run_phase($urandom_range(1, 15), $urandom_range(0, 40), 0, 1'b0);
    run_phase(1, 5, 2047, 1'b0);
    run_phase($urandom_range(0, 15), $urandom_range(0, 255), $urandom_range(2, 12), 1'b0);
    run_phase(15, 0, 1023, 1'b0);
    run_phase($urandom_range(0, 15), $urandom_range(0, 255), $urandom_range(1, 1024), 1'b0);
    run_phase(GAIN_RESET, THRESH_RESET, TLEN_RESET, 1'b0);

    // let any stray result show up before closing
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("run covered %0d words (%0d stopped) under %0d register settings",
             words_taken, stopped_words, settings_used);
    $display("track step advanced %0d times, wrapped %0d times, %0d results checked",
             step_advances, step_wraps, results_checked);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
